/* rtl/wlpc_pkg.sv */
package wlpc_pkg;

    // Input command codes
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_LEN  = 2'd0;
    localparam logic [1:0] KIND_WP   = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_TIMEOUT = 3'd0;
    localparam logic [2:0] ERR_NO_N    = 3'd1;
    localparam logic [2:0] ERR_BAD_LEN = 3'd2;
    localparam logic [2:0] ERR_NO_W    = 3'd3;
    localparam logic [2:0] ERR_NO_E    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_KEEP_LIMIT    = 2'd0;
    localparam logic [1:0] REG_FIRST_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_LINE_TIMEOUT  = 2'd2;

    // Characters
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [14:0] KEEP_RESET  = 15'd64;
    localparam logic [15:0] FIRST_RESET = 16'd10000;
    localparam logic [15:0] LINE_RESET  = 16'd1000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN,
        PH_WP,
        PH_END
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_LEAD_RD,
        ST_LEAD_EV,
        ST_RD,
        ST_EV,
        ST_EMIT
    } state_t;

    // Number parser progress
    typedef enum logic [1:0] {
        PS_WS,
        PS_DIG,
        PS_DONE
    } pstate_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [31:0] longitude;
        logic [14:0] index;
        logic        kept;
        logic        send_ack;
        logic [2:0]  error_code;
    } result_t;

endpackage

/* rtl/waypoint_line_protocol_client_top.sv */
// Channel  | Signals                            | Content
// ---------+------------------------------------+--------------------------------------
// s_axis   | s_tvalid s_tready s_tdata s_tuser  | tuser command, tdata rx_byte
// m_axis   | m_tvalid m_tready m_tdata m_tuser  | tuser kind, tdata result fields
// config   | wr_en wr_addr wr_data              | keep_limit, first_timeout, line_timeout
//
// Bytes, ticks and start commands are accepted whenever s_tready is high.
// A finished line is parsed from the line memory, each character being read
// (ST_RD) and then evaluated (ST_EV); no transaction is taken meanwhile.
// Reset clears control state; the line memory needs no clearing.
// A result waits in the output register; outside a parse, input stalls only if it is full.
module waypoint_line_protocol_client_top #(
    parameter int LINE_CHARS  = 31,
    parameter int FIELD_CHARS = 19
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] value, [63:32] longitude, [78:64] index, [79] kept,
    // [80] send_ack, [83:81] error_code, [87:84] zero
    output logic [87:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        wr_en,
    input  logic [1:0]  wr_addr,
    input  logic [15:0] wr_data
);

    localparam int CNT_W  = $clog2(LINE_CHARS + 1);
    localparam int POS_W  = $clog2(LINE_CHARS + 3);
    localparam int ADDR_W = $clog2(LINE_CHARS);
    localparam int ROOM_W = $clog2(FIELD_CHARS + 1);

    // Configuration registers
    logic [14:0] keep_reg;
    logic [15:0] first_to_reg;
    logic [15:0] line_to_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg     <= wlpc_pkg::KEEP_RESET;
            first_to_reg <= wlpc_pkg::FIRST_RESET;
            line_to_reg  <= wlpc_pkg::LINE_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_addr)
                wlpc_pkg::REG_KEEP_LIMIT:    keep_reg     <= wr_data[14:0];
                wlpc_pkg::REG_FIRST_TIMEOUT: first_to_reg <= wr_data;
                wlpc_pkg::REG_LINE_TIMEOUT:  line_to_reg  <= wr_data;
                default: ;
            endcase
        end
    end

    // Control and parse state
    wlpc_pkg::state_t  state_reg, state_next;
    wlpc_pkg::phase_t  phase_reg, phase_next;
    wlpc_pkg::pstate_t ps_reg, ps_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]       elapsed_reg, elapsed_next;
    logic [14:0]       wp_reg, wp_next;
    logic [14:0]       exp_reg, exp_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ROOM_W-1:0] room_reg, room_next;
    logic              fld_reg, fld_next;
    logic [31:0]       acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic [31:0]       lat_reg, lat_next;
    wlpc_pkg::result_t pend_reg, pend_next;
    wlpc_pkg::result_t out_reg, out_next;
    logic              ov_reg, ov_next;

    // Line memory
    logic [7:0]        mem [LINE_CHARS];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= s_tdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    logic        take;
    logic        out_free;
    logic        is_term;
    logic [15:0] tick_inc;
    logic [15:0] limit;
    logic [7:0]  ch;
    logic        ch_ws;
    logic        ch_dig;
    logic [31:0] acc_x10;
    logic [31:0] num;
    logic [POS_W-1:0] nx;
    logic        fld_end;
    logic [15:0] len16;
    logic [14:0] wp_inc;

    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == wlpc_pkg::ST_RUN) && out_free;
    assign take     = s_tvalid && s_tready;
    assign is_term  = (s_tdata == wlpc_pkg::CH_CR) || (s_tdata == wlpc_pkg::CH_LF)
                      || (s_tdata == wlpc_pkg::CH_NUL);
    assign tick_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign limit    = (phase_reg == wlpc_pkg::PH_LEN) ? first_to_reg : line_to_reg;
    assign mem_we   = take && (s_tuser == wlpc_pkg::CMD_BYTE)
                      && (phase_reg != wlpc_pkg::PH_IDLE) && !is_term;
    assign ch       = rd_data_reg;
    assign ch_ws    = (ch == wlpc_pkg::CH_SPACE)
                      || ((ch >= wlpc_pkg::CH_TAB) && (ch <= wlpc_pkg::CH_CR));
    assign ch_dig   = (ch >= wlpc_pkg::CH_ZERO) && (ch <= wlpc_pkg::CH_NINE);
    assign acc_x10  = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};
    assign num      = neg_reg ? (32'd0 - acc_reg) : acc_reg;
    assign len16    = num[15:0];
    assign wp_inc   = wp_reg + 15'd1;
    assign rd_addr  = (state_reg == wlpc_pkg::ST_LEAD_RD) ? '0 : pos_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        ps_next      = ps_reg;
        cnt_next     = cnt_reg;
        elapsed_next = elapsed_reg;
        wp_next      = wp_reg;
        exp_next     = exp_reg;
        pos_next     = pos_reg;
        room_next    = room_reg;
        fld_next     = fld_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        lat_next     = lat_reg;
        pend_next    = pend_reg;
        out_next     = out_reg;
        ov_next      = ov_reg;
        nx           = pos_reg;
        fld_end      = 1'b0;

        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            wlpc_pkg::ST_RUN:
            begin
                if (take)
                begin
                    if (s_tuser == wlpc_pkg::CMD_START)
                    begin
                        phase_next   = wlpc_pkg::PH_LEN;
                        cnt_next     = '0;
                        elapsed_next = '0;
                        wp_next      = '0;
                    end
                    else if (phase_reg != wlpc_pkg::PH_IDLE)
                    begin
                        if (s_tuser == wlpc_pkg::CMD_TICK)
                        begin
                            elapsed_next = tick_inc;
                            if (tick_inc >= limit)
                            begin
                                phase_next   = wlpc_pkg::PH_IDLE;
                                cnt_next     = '0;
                                elapsed_next = '0;
                                out_next     = '0;
                                out_next.kind       = wlpc_pkg::KIND_ERR;
                                out_next.error_code = wlpc_pkg::ERR_TIMEOUT;
                                ov_next      = 1'b1;
                            end
                        end
                        else if (s_tuser == wlpc_pkg::CMD_BYTE)
                        begin
                            if (is_term)
                            begin
                                state_next = wlpc_pkg::ST_LEAD_RD;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + CNT_W'(1);
                                if (cnt_next == CNT_W'(LINE_CHARS))
                                begin
                                    state_next = wlpc_pkg::ST_LEAD_RD;
                                end
                            end
                        end
                    end
                end
            end

            // Fetch the leading letter of the line, or report an empty line as an error
            wlpc_pkg::ST_LEAD_RD:
            begin
                pend_next    = '0;
                pend_next.kind = wlpc_pkg::KIND_ERR;
                unique case (phase_reg)
                    wlpc_pkg::PH_LEN: pend_next.error_code = wlpc_pkg::ERR_NO_N;
                    wlpc_pkg::PH_WP:  pend_next.error_code = wlpc_pkg::ERR_NO_W;
                    default:          pend_next.error_code = wlpc_pkg::ERR_NO_E;
                endcase
                if (cnt_reg == '0)
                begin
                    phase_next   = wlpc_pkg::PH_IDLE;
                    cnt_next     = '0;
                    elapsed_next = '0;
                    state_next   = wlpc_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = wlpc_pkg::ST_LEAD_EV;
                end
            end

            wlpc_pkg::ST_LEAD_EV:
            begin
                cnt_next     = '0;
                elapsed_next = '0;
                pos_next     = (phase_reg == wlpc_pkg::PH_LEN) ? POS_W'(0) : POS_W'(2);
                room_next    = ROOM_W'(FIELD_CHARS);
                fld_next     = 1'b0;
                acc_next     = '0;
                neg_next     = 1'b0;
                ps_next      = wlpc_pkg::PS_WS;
                cnt_next     = cnt_reg;
                unique case (phase_reg)
                    wlpc_pkg::PH_LEN:
                    begin
                        state_next = (ch == wlpc_pkg::CH_N) ? wlpc_pkg::ST_RD
                                                            : wlpc_pkg::ST_EMIT;
                    end
                    wlpc_pkg::PH_WP:
                    begin
                        state_next = (ch == wlpc_pkg::CH_W) ? wlpc_pkg::ST_RD
                                                            : wlpc_pkg::ST_EMIT;
                    end
                    default:
                    begin
                        state_next = wlpc_pkg::ST_EMIT;
                        if (ch == wlpc_pkg::CH_E)
                        begin
                            pend_next      = '0;
                            pend_next.kind = wlpc_pkg::KIND_DONE;
                        end
                    end
                endcase
                // Every outcome other than a field scan ends the exchange here
                if (state_next == wlpc_pkg::ST_EMIT)
                begin
                    phase_next = wlpc_pkg::PH_IDLE;
                    cnt_next   = '0;
                end
            end

            // Check field bounds and fetch the next character
            wlpc_pkg::ST_RD:
            begin
                if (pos_reg >= POS_W'(cnt_reg))
                begin
                    fld_end = 1'b1;
                    nx      = pos_reg + POS_W'(1);
                end
                else if (room_reg == '0)
                begin
                    fld_end = 1'b1;
                    nx      = pos_reg;
                end
                else
                begin
                    state_next = wlpc_pkg::ST_EV;
                end
            end

            // Consume one character into the number parser, or end the field at a space (not in the length field)
            wlpc_pkg::ST_EV:
            begin
                if ((ch == wlpc_pkg::CH_SPACE)
                    && !((phase_reg == wlpc_pkg::PH_LEN) && fld_reg))
                begin
                    fld_end = 1'b1;
                    nx      = pos_reg + POS_W'(1);
                end
                else
                begin
                    pos_next   = pos_reg + POS_W'(1);
                    room_next  = room_reg - ROOM_W'(1);
                    state_next = wlpc_pkg::ST_RD;
                    case (ps_reg)
                        wlpc_pkg::PS_WS:
                        begin
                            if (ch_ws)
                            begin
                                ps_next = wlpc_pkg::PS_WS;
                            end
                            else if ((ch == wlpc_pkg::CH_PLUS) || (ch == wlpc_pkg::CH_MINUS))
                            begin
                                neg_next = (ch == wlpc_pkg::CH_MINUS);
                                ps_next  = wlpc_pkg::PS_DIG;
                            end
                            else if (ch_dig)
                            begin
                                acc_next = acc_x10 + {24'd0, ch - wlpc_pkg::CH_ZERO};
                                ps_next  = wlpc_pkg::PS_DIG;
                            end
                            else
                            begin
                                ps_next = wlpc_pkg::PS_DONE;
                            end
                        end
                        wlpc_pkg::PS_DIG:
                        begin
                            if (ch_dig)
                            begin
                                acc_next = acc_x10 + {24'd0, ch - wlpc_pkg::CH_ZERO};
                            end
                            else
                            begin
                                ps_next = wlpc_pkg::PS_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Hold the result until the output register is free
            wlpc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next   = pend_reg;
                    ov_next    = 1'b1;
                    state_next = wlpc_pkg::ST_RUN;
                end
            end

            default:
            begin
                state_next = wlpc_pkg::ST_RUN;
            end
        endcase

        // Field boundary: start the second field or settle the line
        if (fld_end)
        begin
            if (!fld_reg)
            begin
                lat_next   = num;
                pos_next   = nx;
                fld_next   = 1'b1;
                room_next  = ROOM_W'(FIELD_CHARS);
                acc_next   = '0;
                neg_next   = 1'b0;
                ps_next    = wlpc_pkg::PS_WS;
                state_next = wlpc_pkg::ST_RD;
            end
            else
            begin
                state_next = wlpc_pkg::ST_EMIT;
                cnt_next   = '0;
                pend_next  = '0;
                if (phase_reg == wlpc_pkg::PH_LEN)
                begin
                    if ((len16 == 16'd0) || len16[15])
                    begin
                        phase_next           = wlpc_pkg::PH_IDLE;
                        pend_next.kind       = wlpc_pkg::KIND_ERR;
                        pend_next.error_code = wlpc_pkg::ERR_BAD_LEN;
                    end
                    else
                    begin
                        exp_next           = len16[14:0];
                        wp_next            = '0;
                        phase_next         = wlpc_pkg::PH_WP;
                        pend_next.kind     = wlpc_pkg::KIND_LEN;
                        pend_next.value    = {16'd0, len16};
                        pend_next.send_ack = 1'b1;
                    end
                end
                else
                begin
                    wp_next             = wp_inc;
                    pend_next.kind      = wlpc_pkg::KIND_WP;
                    pend_next.value     = lat_reg;
                    pend_next.longitude = num;
                    pend_next.index     = wp_reg;
                    pend_next.kept      = (wp_reg < keep_reg);
                    if (wp_inc >= exp_reg)
                    begin
                        phase_next = wlpc_pkg::PH_END;
                    end
                    else
                    begin
                        pend_next.send_ack = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wlpc_pkg::ST_RUN;
            phase_reg   <= wlpc_pkg::PH_IDLE;
            cnt_reg     <= '0;
            elapsed_reg <= '0;
            wp_reg      <= '0;
            exp_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            elapsed_reg <= elapsed_next;
            wp_reg      <= wp_next;
            exp_reg     <= exp_next;
            ov_reg      <= ov_next;
        end
    end

    // Parse datapath and result payload
    always_ff @(posedge clk)
    begin
        ps_reg   <= ps_next;
        pos_reg  <= pos_next;
        room_reg <= room_next;
        fld_reg  <= fld_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        lat_reg  <= lat_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {4'd0, out_reg.error_code, out_reg.send_ack, out_reg.kept,
                       out_reg.index, out_reg.longitude, out_reg.value};

    // The input is stalled for the whole parse of a line.
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != wlpc_pkg::ST_RUN) |-> !s_tready)
        else $error("input accepted during line parse");

    // Idle phase never keeps a running tick count.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wlpc_pkg::PH_IDLE) |-> (elapsed_reg == 16'd0))
        else $error("tick count left over in idle");

    // A stored line never exceeds the memory depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(LINE_CHARS))
        else $error("line count beyond memory depth");

    // Parsing only happens for a line of an active exchange.
    a_parse_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == wlpc_pkg::ST_RD) || (state_reg == wlpc_pkg::ST_EV))
        |-> ((phase_reg == wlpc_pkg::PH_LEN) || (phase_reg == wlpc_pkg::PH_WP)))
        else $error("field scan outside length or waypoint phase");

endmodule
